// File: sv/quaternion_to_rotation_matrix_core_macros.svh
// Assertion macros shared by the quaternion to rotation matrix RTL.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define QRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qrm assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define QRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qrm assertion failed");

`endif

// File: sv/qrm_pkg.sv
// Package: default widths and matrix constants for the quaternion to matrix core.
`default_nettype none
package qrm_pkg;
  localparam int unsigned IN_WIDTH_DEF  = 16;
  localparam int unsigned OUT_WIDTH_DEF = 16;
  localparam int unsigned NUM_ENTRIES   = 9;
  // entry order: m00 m01 m02 m10 m11 m12 m20 m21 m22
  localparam int unsigned E00 = 0;
  localparam int unsigned E01 = 1;
  localparam int unsigned E02 = 2;
  localparam int unsigned E10 = 3;
  localparam int unsigned E11 = 4;
  localparam int unsigned E12 = 5;
  localparam int unsigned E20 = 6;
  localparam int unsigned E21 = 7;
  localparam int unsigned E22 = 8;
endpackage
`default_nettype wire

// File: sv/qrm_if.sv
// Interfaces: quaternion input word and rotation matrix output word channels.
`default_nettype none
interface qrm_in_if #(
  parameter int unsigned IN_WIDTH = qrm_pkg::IN_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] quat_x;
  logic signed [IN_WIDTH-1:0] quat_y;
  logic signed [IN_WIDTH-1:0] quat_z;
  logic signed [IN_WIDTH-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrm_out_if #(
  parameter int unsigned OUT_WIDTH = qrm_pkg::OUT_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] m00;
  logic signed [OUT_WIDTH-1:0] m01;
  logic signed [OUT_WIDTH-1:0] m02;
  logic signed [OUT_WIDTH-1:0] m10;
  logic signed [OUT_WIDTH-1:0] m11;
  logic signed [OUT_WIDTH-1:0] m12;
  logic signed [OUT_WIDTH-1:0] m20;
  logic signed [OUT_WIDTH-1:0] m21;
  logic signed [OUT_WIDTH-1:0] m22;
  logic                        zero_norm;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  output ready);
endinterface
`default_nettype wire

// File: sv/quaternion_to_rotation_matrix_core.sv
// Top level: pipelined quaternion to normalized 3x3 rotation matrix converter.
`default_nettype none
`include "quaternion_to_rotation_matrix_core_macros.svh"
// Takes one quaternion word (x, y, z, w; signed, any length, Q2.13 by default)
// per cycle and returns the rotation matrix of the normalized quaternion, each
// entry num/N with N = w2+x2+y2+z2, rounded to Q1.(OUT_WIDTH-2), ties away from
// zero. A zero quaternion yields the identity with zero_norm set. Throughput is
// one word per cycle unless the output stalls; the stages are: input register, product
// stage (ten parallel multipliers), numerator/norm adders, magnitude stage,
// OUT_WIDTH restoring-division stages (nine dividers side by side, one quotient
// bit each), and the rounding/output register. The whole pipe advances when the
// output register is empty or being taken, so a stall holds every stage in place.
module quaternion_to_rotation_matrix_core #(
  parameter int unsigned IN_WIDTH  = qrm_pkg::IN_WIDTH_DEF,
  parameter int unsigned OUT_WIDTH = qrm_pkg::OUT_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qrm_in_if.sink    in_i,
  qrm_out_if.source out_o
);
  localparam int unsigned NE = qrm_pkg::NUM_ENTRIES;
  localparam int unsigned PW = 2 * IN_WIDTH;       // signed product
  localparam int unsigned SW = 2 * IN_WIDTH + 2;   // sums, remainders
  localparam int unsigned QW = OUT_WIDTH;          // quotient bits
  localparam int unsigned FB = OUT_WIDTH - 2;      // fraction bits
  localparam logic [QW-1:0] ONE = QW'(1) << FB;

  logic adv;  // whole pipe moves

  // stage 1: input register
  logic                       v1_q;
  logic signed [IN_WIDTH-1:0] x_q, y_q, z_q, w_q;

  // stage 2: products
  logic                 v2_q;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;

  // stage 3: signed numerators and norm
  logic                 v3_q;
  logic signed [SW-1:0] num_q [NE];
  logic        [SW-1:0] n3_q;

  // divider pipe: index 0 is the magnitude stage, k+1 after quotient bit k
  logic          dv_q   [QW+1];
  logic          dz_q   [QW+1];
  logic [SW-1:0] dn_q   [QW+1];
  logic [SW-1:0] dr_q   [QW+1][NE];
  logic [QW-1:0] dquo_q [QW+1][NE];
  logic [NE-1:0] dneg_q [QW+1];

  // output register
  logic                        ov_q;
  logic signed [OUT_WIDTH-1:0] m_q [NE];
  logic                        zn_q;

  assign adv      = !ov_q || out_o.ready;
  assign in_i.ready = adv;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      dv_q[0] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_q[0] <= v3_q;
      ov_q <= dv_q[QW];
    end
  end

  // front stages: capture, multiply, sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q  <= in_i.quat_x;
      y_q  <= in_i.quat_y;
      z_q  <= in_i.quat_z;
      w_q  <= in_i.quat_w;
      xx_q <= PW'(x_q) * PW'(x_q);
      yy_q <= PW'(y_q) * PW'(y_q);
      zz_q <= PW'(z_q) * PW'(z_q);
      ww_q <= PW'(w_q) * PW'(w_q);
      xy_q <= PW'(x_q) * PW'(y_q);
      zw_q <= PW'(z_q) * PW'(w_q);
      xz_q <= PW'(x_q) * PW'(z_q);
      yw_q <= PW'(y_q) * PW'(w_q);
      yz_q <= PW'(y_q) * PW'(z_q);
      xw_q <= PW'(x_q) * PW'(w_q);
      n3_q <= SW'(xx_q) + SW'(yy_q) + SW'(zz_q) + SW'(ww_q);
      num_q[qrm_pkg::E00] <= SW'(ww_q) + SW'(xx_q) - SW'(yy_q) - SW'(zz_q);
      num_q[qrm_pkg::E11] <= SW'(ww_q) + SW'(yy_q) - SW'(xx_q) - SW'(zz_q);
      num_q[qrm_pkg::E22] <= SW'(ww_q) + SW'(zz_q) - SW'(xx_q) - SW'(yy_q);
      num_q[qrm_pkg::E01] <= (SW'(xy_q) - SW'(zw_q)) <<< 1;
      num_q[qrm_pkg::E02] <= (SW'(xz_q) + SW'(yw_q)) <<< 1;
      num_q[qrm_pkg::E10] <= (SW'(xy_q) + SW'(zw_q)) <<< 1;
      num_q[qrm_pkg::E12] <= (SW'(yz_q) - SW'(xw_q)) <<< 1;
      num_q[qrm_pkg::E20] <= (SW'(xz_q) - SW'(yw_q)) <<< 1;
      num_q[qrm_pkg::E21] <= (SW'(yz_q) + SW'(xw_q)) <<< 1;
      // magnitude stage
      dn_q[0] <= n3_q;
      dz_q[0] <= (n3_q == '0);
      for (int e = 0; e < NE; e++) begin
        dneg_q[0][e] <= num_q[e][SW-1];
        dr_q[0][e]   <= num_q[e][SW-1] ? SW'(-num_q[e]) : SW'(num_q[e]);
        dquo_q[0][e] <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [SW-1:0] rs [NE];
    logic          ge [NE];
    always_comb begin
      for (int e = 0; e < NE; e++) begin
        rs[e] = (k == 0) ? dr_q[k][e] : (dr_q[k][e] << 1);
        ge[e] = (rs[e] >= dn_q[k]);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dn_q[k+1]   <= dn_q[k];
        dz_q[k+1]   <= dz_q[k];
        dneg_q[k+1] <= dneg_q[k];
        for (int e = 0; e < NE; e++) begin
          dr_q[k+1][e]   <= ge[e] ? (rs[e] - dn_q[k]) : rs[e];
          dquo_q[k+1][e] <= {dquo_q[k][e][QW-2:0], ge[e]};
        end
      end
    end
  end

  // round half away from zero, clamp to one, apply sign; zero norm gives identity
  logic [QW:0]   rnd [NE];
  logic [QW-1:0] mag [NE];
  always_comb begin
    for (int e = 0; e < NE; e++) begin
      rnd[e] = ((QW+1)'(dquo_q[QW][e]) + (QW+1)'(1)) >> 1;
      mag[e] = (rnd[e] > (QW+1)'(ONE)) ? ONE : rnd[e][QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zn_q <= dz_q[QW];
      for (int e = 0; e < NE; e++) begin
        if (dz_q[QW]) begin
          m_q[e] <= (e == qrm_pkg::E00 || e == qrm_pkg::E11 || e == qrm_pkg::E22) ?
                    ONE : '0;
        end else begin
          m_q[e] <= dneg_q[QW][e] ? -mag[e] : mag[e];
        end
      end
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.m00       = m_q[qrm_pkg::E00];
  assign out_o.m01       = m_q[qrm_pkg::E01];
  assign out_o.m02       = m_q[qrm_pkg::E02];
  assign out_o.m10       = m_q[qrm_pkg::E10];
  assign out_o.m11       = m_q[qrm_pkg::E11];
  assign out_o.m12       = m_q[qrm_pkg::E12];
  assign out_o.m20       = m_q[qrm_pkg::E20];
  assign out_o.m21       = m_q[qrm_pkg::E21];
  assign out_o.m22       = m_q[qrm_pkg::E22];
  assign out_o.zero_norm = zn_q;

  // zero quaternion must give ones on the diagonal and zero m01, m12, m20
  `QRM_ASSERT_IMP(a_zero_diag, ov_q && zn_q,
    m_q[qrm_pkg::E00] == ONE && m_q[qrm_pkg::E11] == ONE && m_q[qrm_pkg::E22] == ONE)
  `QRM_ASSERT_IMP(a_zero_offd, ov_q && zn_q,
    m_q[qrm_pkg::E01] == '0 && m_q[qrm_pkg::E12] == '0 && m_q[qrm_pkg::E20] == '0)
  // entry m00 never leaves [-1, +1]
  `QRM_ASSERT_IMP(a_range, ov_q,
    m_q[qrm_pkg::E00] <= $signed(ONE) && m_q[qrm_pkg::E00] >= -$signed(ONE))
  // a stall holds the stage 3 valid bit and norm
  `QRM_ASSERT_NXT(a_hold, !adv && v3_q, v3_q && $stable(n3_q))
  // a taken input word reaches stage 1
  `QRM_ASSERT_NXT(a_enter, in_i.valid && adv, v1_q)
endmodule
`default_nettype wire
